>>> rtl/sfd_pkg.sv
// ----------------------------------------------------------------------------
// sfd_pkg
// shared types and constants of the slip frame decoder
// ----------------------------------------------------------------------------
package sfd_pkg;

    // width of the packet position counter, legal range 8 to 32
    localparam int unsigned POSITION_WIDTH = 16;
    // width of the reported byte position field
    localparam int unsigned POS_OUT_WIDTH  = 16;
    localparam int unsigned BYTE_WIDTH     = 8;
    // widened counter, always one bit wider than the largest counter
    localparam int unsigned POS_WIDE_WIDTH = 33;

    // slip byte codes
    localparam logic [BYTE_WIDTH-1:0] CODE_END     = 8'o300;
    localparam logic [BYTE_WIDTH-1:0] CODE_ESC     = 8'o333;
    localparam logic [BYTE_WIDTH-1:0] CODE_ESC_END = 8'o334;
    localparam logic [BYTE_WIDTH-1:0] CODE_ESC_ESC = 8'o335;

    localparam logic [POS_OUT_WIDTH-1:0] POS_OUT_MAX = {POS_OUT_WIDTH{1'b1}};

    typedef logic [POSITION_WIDTH-1:0] t_position;

    // one decoded result
    typedef struct packed {
        logic [BYTE_WIDTH-1:0]    packet_byte;
        logic                     end_of_packet;
        logic [POS_OUT_WIDTH-1:0] byte_position;
    } t_result;

    // clamp the internal counter into the reported field
    function automatic logic [POS_OUT_WIDTH-1:0] clamp_position(input t_position cnt);
        logic [POS_WIDE_WIDTH-1:0] wide;
        wide = {{(POS_WIDE_WIDTH-POSITION_WIDTH){1'b0}}, cnt};
        if (wide > {{(POS_WIDE_WIDTH-POS_OUT_WIDTH){1'b0}}, POS_OUT_MAX}) begin
            return POS_OUT_MAX;
        end
        return wide[POS_OUT_WIDTH-1:0];
    endfunction

endpackage

>>> rtl/sfd_core.sv
// ----------------------------------------------------------------------------
// sfd_core
// decode state and slip decode logic, one byte per cycle while i_fire is high
// ----------------------------------------------------------------------------
module sfd_core
    import sfd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_fire,
    input  logic [BYTE_WIDTH-1:0] i_byte,
    output logic                  o_res_valid,
    output t_result               o_res
);

    localparam t_position POS_TOP = {POSITION_WIDTH{1'b1}};

    logic [BYTE_WIDTH-1:0] r_held_byte, n_held_byte;
    logic                  r_held_valid, n_held_valid;
    logic                  r_esc_pending, n_esc_pending;
    t_position             r_pos, n_pos;

    always_comb begin
        n_held_byte   = r_held_byte;
        n_held_valid  = r_held_valid;
        n_esc_pending = r_esc_pending;
        n_pos         = r_pos;
        o_res_valid   = 1'b0;
        o_res.packet_byte   = r_held_byte;
        o_res.end_of_packet = 1'b0;
        o_res.byte_position = clamp_position(r_pos);

        if (i_fire) begin
            priority if (i_byte == CODE_END) begin
                o_res_valid         = r_held_valid;
                o_res.end_of_packet = 1'b1;
                n_held_valid        = 1'b0;
                n_esc_pending       = 1'b0;
                n_pos               = '0;
            end else if (r_esc_pending && i_byte == CODE_ESC_END) begin
                n_held_byte   = CODE_END;
                n_esc_pending = 1'b0;
            end else if (r_esc_pending && i_byte == CODE_ESC_ESC) begin
                n_held_byte   = CODE_ESC;
                n_esc_pending = 1'b0;
            end else begin
                // plain byte, or an escape that stays literal
                o_res_valid = r_held_valid;
                if (r_held_valid && r_pos != POS_TOP) begin
                    n_pos = r_pos + t_position'(1);
                end
                n_held_byte   = i_byte;
                n_held_valid  = 1'b1;
                n_esc_pending = (i_byte == CODE_ESC);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_byte   <= '0;
            r_held_valid  <= 1'b0;
            r_esc_pending <= 1'b0;
            r_pos         <= '0;
        end else begin
            r_held_byte   <= n_held_byte;
            r_held_valid  <= n_held_valid;
            r_esc_pending <= n_esc_pending;
            r_pos         <= n_pos;
        end
    end

endmodule

>>> rtl/sfd_out_buf.sv
// ----------------------------------------------------------------------------
// sfd_out_buf
// two-entry result buffer, decouples the decoder from output stalls
// ----------------------------------------------------------------------------
module sfd_out_buf
    import sfd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_wr,
    input  t_result i_res,
    output logic    o_space,
    output logic    o_valid,
    output t_result o_res,
    input  logic    i_rd
);

    t_result    r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_cnt;
    logic       rd_fire;

    assign o_space = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_res   = r_mem[r_rd_ptr];
    assign rd_fire = i_rd && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (rd_fire) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            unique case ({i_wr, rd_fire})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

>>> rtl/slip_frame_decoder_unit.sv
// ----------------------------------------------------------------------------
// slip_frame_decoder_unit
// slip stream decoder, raw bytes in, decoded packet bytes out
// ----------------------------------------------------------------------------
// takes one raw slip byte per transaction and returns decoded packet bytes.
// every byte passes an input register, a combinational decode against the
// held-byte state, and a two-entry result buffer; one byte is taken per clock
// as long as the output side keeps up, and a result leaves the unit only
// from the buffer register. the decoded byte is held back by one input byte,
// so a packet byte comes out when the next raw byte (or the closing end byte)
// arrives; end_of_packet rides on tlast. an end byte with nothing held (empty
// packet) produces nothing. an escape followed by anything other than the two
// escape codes is passed through literally. the byte position is counted in a
// POSITION_WIDTH-bit saturating counter and reported clamped to 16 bits.
// the input ready depends only on registers, never on the output tready.
// ----------------------------------------------------------------------------
module slip_frame_decoder_unit
    import sfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] raw_byte
    // output stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // [7:0] packet_byte, [23:8] byte_position
    output logic        o_m_tlast    // end_of_packet
);

    // input register
    logic                  r_in_valid;
    logic [BYTE_WIDTH-1:0] r_in_byte;

    logic    buf_space;
    logic    dec_fire;
    logic    res_valid;
    t_result res;
    t_result out_res;

    // the staged byte moves into the decoder whenever the buffer has room
    assign dec_fire   = r_in_valid && buf_space;
    assign o_s_tready = !r_in_valid || buf_space;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    // payload register, no reset needed
    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
        end
    end

    sfd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (dec_fire),
        .i_byte      (r_in_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    sfd_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (res_valid),
        .i_res   (res),
        .o_space (buf_space),
        .o_valid (o_m_tvalid),
        .o_res   (out_res),
        .i_rd    (i_m_tready)
    );

    assign o_m_tdata = {out_res.byte_position, out_res.packet_byte};
    assign o_m_tlast = out_res.end_of_packet;

endmodule

>>> tb/slip_stream_checker.sv
// ----------------------------------------------------------------------------
// slip_stream_checker
// watches both streams of the slip decoder, predicts and compares results
// ----------------------------------------------------------------------------
// every raw byte taken on the input stream runs through a local decoder model
// that may release one expected packet byte. every transaction on the output
// stream is matched against the oldest expected byte, field by field.
// ----------------------------------------------------------------------------
module slip_stream_checker
    import sfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] raw_byte
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [23:0] i_m_tdata,   // [7:0] packet_byte, [23:8] byte_position
    input  logic        i_m_tlast,   // end_of_packet
    output int          o_fail_count,
    output int          o_pending_count,
    output int          o_bytes_checked,
    output int          o_packets_checked,
    output int          o_top_position
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_REPORTS = 10;

    // model of the decoder state
    logic [BYTE_WIDTH-1:0] hold_byte;
    logic                  hold_full;
    logic                  esc_open;
    t_position             hold_pos;

    t_result expected_bytes[$];

    // position as the output field reports it
    function automatic logic [POS_OUT_WIDTH-1:0] reported_position(input t_position cnt);
        logic [63:0] wide;
        wide = 64'(cnt);
        if (wide > 64'(POS_OUT_MAX)) begin
            return POS_OUT_MAX;
        end
        return wide[POS_OUT_WIDTH-1:0];
    endfunction

    function automatic t_result held_result(input logic last);
        t_result r;
        r.packet_byte   = hold_byte;
        r.end_of_packet = last;
        r.byte_position = reported_position(hold_pos);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        logic [BYTE_WIDTH-1:0] raw;
        if (!i_rst_n) begin
            hold_byte = '0;
            hold_full = 1'b0;
            esc_open  = 1'b0;
            hold_pos  = '0;
            expected_bytes.delete();
        end else begin
            // output first: a byte taken at this edge cannot release a result now
            if (i_m_tvalid && i_m_tready) begin
                got.packet_byte   = i_m_tdata[7:0];
                got.byte_position = i_m_tdata[23:8];
                got.end_of_packet = i_m_tlast;
                if (expected_bytes.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= MAX_REPORTS) begin
                        $display("unexpected packet byte: byte %h last %b pos %0d",
                                 got.packet_byte, got.end_of_packet, got.byte_position);
                    end
                end else begin
                    want = expected_bytes.pop_front();
                    if (got.packet_byte !== want.packet_byte ||
                        got.end_of_packet !== want.end_of_packet ||
                        got.byte_position !== want.byte_position) begin
                        o_fail_count++;
                        if (o_fail_count <= MAX_REPORTS) begin
                            $display("packet byte mismatch: expected byte %h last %b pos %0d, %s",
                                     want.packet_byte, want.end_of_packet, want.byte_position,
                                     $sformatf("got byte %h last %b pos %0d", got.packet_byte,
                                               got.end_of_packet, got.byte_position));
                        end
                    end
                    o_bytes_checked++;
                    if (want.end_of_packet) begin
                        o_packets_checked++;
                    end
                    if (int'(want.byte_position) > o_top_position) begin
                        o_top_position = int'(want.byte_position);
                    end
                end
            end

            if (i_s_tvalid && i_s_tready) begin
                raw = i_s_tdata;
                if (raw == CODE_END) begin
                    // closing end: flush the held byte, an empty packet gives nothing
                    if (hold_full) begin
                        expected_bytes.push_back(held_result(1'b1));
                    end
                    hold_full = 1'b0;
                    esc_open  = 1'b0;
                    hold_pos  = '0;
                end else if (esc_open && raw == CODE_ESC_END) begin
                    hold_byte = CODE_END;
                    esc_open  = 1'b0;
                end else if (esc_open && raw == CODE_ESC_ESC) begin
                    // decoded esc is plain data, no new escape
                    hold_byte = CODE_ESC;
                    esc_open  = 1'b0;
                end else begin
                    if (hold_full) begin
                        expected_bytes.push_back(held_result(1'b0));
                        if (hold_pos != '1) begin
                            hold_pos = hold_pos + t_position'(1);
                        end
                    end
                    hold_byte = raw;
                    hold_full = 1'b1;
                    esc_open  = (raw == CODE_ESC);
                end
            end
        end
        o_pending_count = expected_bytes.size();
    end

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// stimulus and verdict for the slip frame decoder
// ----------------------------------------------------------------------------
// feeds raw slip bytes into the decoder: a directed set of escape and framing
// corner cases, then random traffic that is mostly properly framed packets
// with random payload, mixed with noise and broken escapes. four idle phases
// vary the pacing of both streams. the checker predicts and compares every
// packet byte.
// ----------------------------------------------------------------------------
module tb
    import sfd_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS    = 1150;
    localparam int PHASE_ITEMS     = RANDOM_ITEMS / 4;
    localparam int WATCHDOG_LIMIT  = 5000;
    // a result is registered in the result buffer before it is seen on the output
    localparam int DRAIN_CYCLES    = 8;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata  = '0;   // [7:0] raw_byte
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [23:0] o_m_tdata;         // [7:0] packet_byte, [23:8] byte_position
    logic        o_m_tlast;         // end_of_packet

    int fail_count;
    int pending_count;
    int bytes_checked;
    int packets_checked;
    int top_position;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int items_sent = 0;
    int quiet_cycles = 0;

    always #1 i_clk = ~i_clk;

    slip_frame_decoder_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    slip_stream_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_s_tvalid        (i_s_tvalid),
        .i_s_tready        (o_s_tready),
        .i_s_tdata         (i_s_tdata),
        .i_m_tvalid        (o_m_tvalid),
        .i_m_tready        (i_m_tready),
        .i_m_tdata         (o_m_tdata),
        .i_m_tlast         (o_m_tlast),
        .o_fail_count      (fail_count),
        .o_pending_count   (pending_count),
        .o_bytes_checked   (bytes_checked),
        .o_packets_checked (packets_checked),
        .o_top_position    (top_position)
    );

    // receiver side: random stall per cycle at the current phase rate
    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog: cycles in a row with no transaction on either stream
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d packet bytes outstanding", pending_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    // one raw byte as a single input transaction, with random idle before it
    task automatic push_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        @(posedge i_clk);
        while (!o_s_tready) begin
            @(posedge i_clk);
        end
        items_sent++;
    endtask

    // random byte with the slip codes drawn far more often than chance
    function automatic logic [7:0] coded_byte();
        case ($urandom_range(9))
            0: return CODE_END;
            1: return CODE_ESC;
            2: return CODE_ESC_END;
            3: return CODE_ESC_ESC;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // properly framed packet: payload escaped as a sender would, then end
    task automatic push_packet(input int len);
        logic [7:0] p;
        for (int k = 0; k < len; k++) begin
            p = coded_byte();
            if (p == CODE_END) begin
                push_byte(CODE_ESC);
                push_byte(CODE_ESC_END);
            end else if (p == CODE_ESC) begin
                push_byte(CODE_ESC);
                push_byte(CODE_ESC_ESC);
            end else begin
                push_byte(p);
            end
        end
        push_byte(CODE_END);
    endtask

    task automatic run_random(input int count);
        int start;
        int pick;
        start = items_sent;
        while (items_sent - start < count) begin
            pick = $urandom_range(99);
            if (pick < 78) begin
                // mostly short packets, now and then a longer one
                if ($urandom_range(19) == 0) begin
                    push_packet($urandom_range(40, 13));
                end else begin
                    push_packet($urandom_range(12));
                end
            end else if (pick < 90) begin
                // noise burst of raw bytes
                repeat ($urandom_range(6, 1)) push_byte(coded_byte());
            end else begin
                // broken escapes: esc at packet end, or esc before a random coded byte
                push_byte(8'($urandom_range(255)) & 8'h3f);
                push_byte(CODE_ESC);
                if ($urandom_range(1)) begin
                    push_byte(CODE_END);
                end else begin
                    push_byte(coded_byte());
                end
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // phase 0: no idling on either side
        send_idle_pct  = 0;
        recv_stall_pct = 0;

        // directed corner cases
        push_byte(CODE_END);                          // empty packet, no result
        push_byte(8'h00);                             // byte extremes
        push_byte(8'hff);
        push_byte(CODE_END);
        push_byte(CODE_ESC);                          // escaped end
        push_byte(CODE_ESC_END);
        push_byte(CODE_ESC);                          // escaped esc
        push_byte(CODE_ESC_ESC);
        push_byte(CODE_ESC_END);                      // decoded esc starts no escape
        push_byte(CODE_ESC);                          // esc before plain data
        push_byte(8'h41);
        push_byte(CODE_ESC);                          // esc before esc
        push_byte(CODE_ESC);
        push_byte(CODE_ESC_ESC);
        push_byte(CODE_END);
        push_byte(CODE_END);                          // back to back ends
        push_byte(CODE_ESC_ESC);                      // escape codes with no escape
        push_byte(CODE_ESC_END);
        push_byte(CODE_ESC);                          // packet ends in open esc
        push_byte(CODE_END);
        push_byte(8'h5a);                             // single byte packet
        push_byte(CODE_END);

        run_random(PHASE_ITEMS);

        // phase 1: sender idle most of the time
        send_idle_pct  = 67;
        recv_stall_pct = 0;
        run_random(PHASE_ITEMS);

        // phase 2: receiver stalling most of the time
        send_idle_pct  = 0;
        recv_stall_pct = 67;
        run_random(PHASE_ITEMS);

        // phase 3: both sides idle now and then
        send_idle_pct  = 22;
        recv_stall_pct = 22;
        run_random(RANDOM_ITEMS - 3 * PHASE_ITEMS);

        // close any open packet so the held byte comes out
        push_byte(CODE_END);
        i_s_tvalid <= 1'b0;
        recv_stall_pct = 0;

        // drain, watchdog bounds the wait
        while (pending_count != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d raw bytes: framing and escape corners, then four pacing phases",
                 items_sent);
        $display("checked %0d packet bytes in %0d packets, highest position %0d",
                 bytes_checked, packets_checked, top_position);
        if (fail_count == 0 && pending_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d failures, %0d packet bytes outstanding", fail_count, pending_count);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
